// ===== design/vbtk_pkg.sv =====
// ----------------------------------------------------------------------------
// vbtk_pkg: shared types and constants for view blend top-k weights
// Request and result payloads, sizes of the cosine store and the pick list.
// ----------------------------------------------------------------------------
package vbtk_pkg;

  localparam int MAX_CAMERAS = 256;
  localparam int MAX_PICK    = 16;
  localparam int CAM_AW      = $clog2(MAX_CAMERAS);
  localparam int CNT_W       = CAM_AW + 1;
  localparam int PICK_AW     = $clog2(MAX_PICK);
  localparam int SEL_W       = 5;
  localparam int DIV_W       = 64;
  localparam int RAW_W       = 48;
  localparam int SUM_W       = RAW_W + PICK_AW;

  localparam logic CMD_BEGIN  = 1'b0;
  localparam logic CMD_CAMERA = 1'b1;

  localparam logic [SEL_W-1:0] MAX_SEL_RESET = 5'd4;
  localparam logic [15:0]      COS_MAX       = 16'd32767;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
    logic               last_camera;
  } req_t;

  typedef struct packed {
    logic [7:0]  camera_index;
    logic [16:0] weight;
    logic        last_out;
  } res_t;

endpackage

// ===== design/vbtk_div.sv =====
// ----------------------------------------------------------------------------
// vbtk_div: restoring divider
// Unsigned 64 by 64 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbtk_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vbtk_pkg::DIV_W-1:0] dividend,
  input  logic [vbtk_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [vbtk_pkg::DIV_W-1:0] quotient
);
  import vbtk_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [DIV_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (cnt == CW'(DIV_W - 1));
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= fits ? shifted - {1'b0, dvs} : shifted;
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== design/vbtk_isqrt.sv =====
// ----------------------------------------------------------------------------
// vbtk_isqrt: integer square root
// Floor square root of a 64 bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vbtk_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);
  import vbtk_pkg::*;

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        run;
  logic [63:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (bitv == 64'd1);
      if (start) begin
        v    <= value;
        res  <= '0;
        bitv <= 64'd1 << 62;
        run  <= 1'b1;
      end else if (run) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign root = res[31:0];

endmodule

// ===== design/view_blend_topk_weights.sv =====
// ----------------------------------------------------------------------------
// view_blend_topk_weights: cosine top-k view blending weights
//
//   port group       dir  handshake                 payload
//   start/request    in   start & !busy             req_t
//   cfg_we/cfg_data  in   cfg_we                    max_selected
//   result_valid     out  one-cycle strobe          res_t
//
// A begin request checks for a zero-length direction and then goes idle; else
// it normalizes the direction by single-bit shifts, squares and sums its
// components, takes the root, then runs three divides. A camera request adds
// the dot-product multiplies and a cosine step. The last camera then adds
// one scan of the cosine store and one weight divide for each pick.
// Reset is synchronous; busy is low right after it. Results cannot stall.
// ----------------------------------------------------------------------------
module view_blend_topk_weights (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  vbtk_pkg::req_t              request,
  output logic                        busy,
  input  logic                        cfg_we,
  input  logic [vbtk_pkg::SEL_W-1:0]  cfg_data,
  output logic                        result_valid,
  output vbtk_pkg::res_t              result
);
  import vbtk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_NORM, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_DIV_GO, S_DIV_WAIT,
    S_DOT_MUL, S_DOT_ACC, S_COS, S_SEL_INIT, S_SCAN, S_RAW1, S_RAW2, S_RAW3,
    S_W_GO, S_W_WAIT
  } state_t;

  state_t state;

  logic [SEL_W-1:0]   max_sel;
  logic               is_cam;
  logic               is_last;
  logic signed [31:0] pt [3];
  logic signed [15:0] vdir [3];
  logic signed [15:0] qdir [3];
  logic [32:0]        u [3];
  logic [2:0]         d_neg;
  logic [1:0]         idx;
  logic [63:0]        sum_sq;
  logic [31:0]        len;
  logic [63:0]        prod;
  logic               dsign;
  logic signed [33:0] dot;
  logic [CNT_W-1:0]   count;

  logic [PICK_AW:0]   n;
  logic [PICK_AW:0]   k;
  logic [CNT_W-1:0]   j;
  logic               rv;
  logic [CAM_AW-1:0]  jd;
  logic               have;
  logic signed [15:0] bestc;
  logic [CAM_AW-1:0]  bestj;
  logic signed [15:0] prevc;
  logic [CAM_AW-1:0]  previdx;
  logic [CAM_AW-1:0]  pick [MAX_PICK];
  logic [RAW_W-1:0]   rawv [MAX_PICK];
  logic [SUM_W-1:0]   sum;

  // cosine store
  logic signed [15:0] cos_mem [MAX_CAMERAS];
  logic               cos_we;
  logic signed [15:0] cos_wd;
  logic               rd_en;
  logic signed [15:0] rd_data;

  // shared units
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   div_a;
  logic [DIV_W-1:0]   div_b;
  logic [DIV_W-1:0]   div_q;

  logic [32:0]        m_cur;
  logic signed [32:0] d_in [3];
  logic [33:0]        dot_mag;
  logic [17:0]        cos_r;
  logic               elig;
  logic [CNT_W-1:0]   n_lim;
  logic [15:0]        div_c;
  logic [PICK_AW-1:0] ki;
  logic               emit;

  function automatic logic [15:0] mag16(input logic signed [15:0] x);
    mag16 = x[15] ? 16'(-x) : 16'(x);
  endfunction

  assign ki = k[PICK_AW-1:0];

  always_comb begin
    d_in[0] = {request.pos_x[31], request.pos_x} -
              (request.command == CMD_BEGIN ? {request.pt_x[31], request.pt_x} :
                                              {pt[0][31], pt[0]});
    d_in[1] = {request.pos_y[31], request.pos_y} -
              (request.command == CMD_BEGIN ? {request.pt_y[31], request.pt_y} :
                                              {pt[1][31], pt[1]});
    d_in[2] = {request.pos_z[31], request.pos_z} -
              (request.command == CMD_BEGIN ? {request.pt_z[31], request.pt_z} :
                                              {pt[2][31], pt[2]});
    m_cur = u[0];
    if (u[1] > m_cur) m_cur = u[1];
    if (u[2] > m_cur) m_cur = u[2];
    dot_mag = dot[33] ? 34'(-dot) : 34'(dot);
    cos_r   = 18'((dot_mag + 34'd16384) >> 15);
    cos_wd  = (cos_r > 18'(COS_MAX)) ? $signed(COS_MAX) : $signed(cos_r[15:0]);
    if (dot[33]) cos_wd = -cos_wd;
    cos_we  = (state == S_COS);
    elig    = (k == '0) || (rd_data < prevc) || (rd_data == prevc && jd > previdx);
    n_lim   = (max_sel > SEL_W'(MAX_PICK)) ? CNT_W'(MAX_PICK) : CNT_W'(max_sel);
    if (count < n_lim) n_lim = count;
    div_c   = (div_q > DIV_W'(COS_MAX)) ? COS_MAX : div_q[15:0];
    rd_en   = (state == S_SCAN) && (j < count);
    emit    = (state == S_W_GO && sum == '0) || (state == S_W_WAIT && div_done);
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      S_SQ_MUL: begin
        mul_a = u[idx][31:0];
        mul_b = u[idx][31:0];
      end
      S_DOT_MUL: begin
        mul_a = 32'(mag16(qdir[idx]));
        mul_b = 32'(mag16(vdir[idx]));
      end
      S_RAW1: begin
        mul_a = 32'(mag16(bestc));
        mul_b = 32'(mag16(bestc));
      end
      S_RAW2: begin
        mul_a = prod[31:0];
        mul_b = prod[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_start  = (state == S_SQ_ACC) && (idx == 2'd2);
  assign div_start = (state == S_DIV_GO) || (state == S_W_GO && sum != '0);

  always_comb begin
    if (state == S_W_GO) begin
      div_a = {rawv[ki], 16'b0} + DIV_W'(sum >> 1);
      div_b = DIV_W'(sum);
    end else begin
      div_a = (DIV_W'(u[idx]) << 15) + DIV_W'(len >> 1);
      div_b = DIV_W'(len);
    end
  end

  vbtk_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sum_sq + prod),
    .done  (sq_done),
    .root  (sq_root)
  );

  vbtk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cos_we) cos_mem[count[CAM_AW-1:0]] <= cos_wd;
    if (rd_en) rd_data <= cos_mem[j[CAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_sel      <= MAX_SEL_RESET;
      count        <= '0;
      result_valid <= 1'b0;
      rv           <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vdir[i] <= '0;
        pt[i]   <= '0;
      end
    end else begin
      result_valid <= emit;
      if (cfg_we) max_sel <= cfg_data;
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (start) begin
            is_cam  <= request.command;
            is_last <= request.last_camera;
            for (int i = 0; i < 3; i++) begin
              d_neg[i] <= d_in[i][32];
              u[i]     <= d_in[i][32] ? 33'(-d_in[i]) : 33'(d_in[i]);
            end
            if (request.command == CMD_BEGIN) begin
              pt[0] <= request.pt_x;
              pt[1] <= request.pt_y;
              pt[2] <= request.pt_z;
              count <= '0;
              state <= S_CHECK;
            end else if (count < CNT_W'(MAX_CAMERAS)) begin
              state <= S_CHECK;
            end else if (request.last_camera) begin
              state <= S_SEL_INIT;
            end
          end
        end
        S_CHECK: begin
          idx    <= '0;
          sum_sq <= '0;
          if (m_cur == '0) begin
            for (int i = 0; i < 3; i++) qdir[i] <= '0;
            if (is_cam) begin
              dot   <= '0;
              state <= S_DOT_MUL;
            end else begin
              for (int i = 0; i < 3; i++) vdir[i] <= '0;
              state <= S_IDLE;
            end
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (m_cur[32:30] != '0) begin
            for (int i = 0; i < 3; i++) u[i] <= u[i] >> 1;
          end else if (!m_cur[29]) begin
            for (int i = 0; i < 3; i++) u[i] <= u[i] << 1;
          end else begin
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          sum_sq <= sum_sq + prod;
          if (idx == 2'd2) begin
            state <= S_SQRT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            len   <= sq_root;
            idx   <= '0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            qdir[idx] <= d_neg[idx] ? -$signed(div_c) : $signed(div_c);
            if (idx == 2'd2) begin
              idx <= '0;
              dot <= '0;
              state <= is_cam ? S_DOT_MUL : S_IDLE;
              if (!is_cam) begin
                vdir[0] <= qdir[0];
                vdir[1] <= qdir[1];
                vdir[2] <= d_neg[2] ? -$signed(div_c) : $signed(div_c);
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_DOT_MUL: begin
          dsign <= qdir[idx][15] ^ vdir[idx][15];
          state <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          dot <= dsign ? dot - $signed(34'(prod)) : dot + $signed(34'(prod));
          if (idx == 2'd2) begin
            state <= S_COS;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DOT_MUL;
          end
        end
        S_COS: begin
          count <= count + 1'b1;
          state <= is_last ? S_SEL_INIT : S_IDLE;
        end
        S_SEL_INIT: begin
          n     <= n_lim[PICK_AW:0];
          k     <= '0;
          sum   <= '0;
          j     <= '0;
          rv    <= 1'b0;
          have  <= 1'b0;
          if (n_lim == '0) begin
            count <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) j <= j + 1'b1;
          rv <= rd_en;
          jd <= j[CAM_AW-1:0];
          if (rv && elig && (!have || rd_data > bestc)) begin
            have  <= 1'b1;
            bestc <= rd_data;
            bestj <= jd;
          end
          if (!rd_en && !rv) begin
            pick[ki] <= bestj;
            prevc    <= bestc;
            previdx  <= bestj;
            state    <= S_RAW1;
          end
        end
        S_RAW1: state <= S_RAW2;
        S_RAW2: state <= S_RAW3;
        S_RAW3: begin
          rawv[ki] <= prod[RAW_W+11:12];
          sum      <= sum + SUM_W'(prod[RAW_W+11:12]);
          j        <= '0;
          rv       <= 1'b0;
          have     <= 1'b0;
          if (k == n - 1'b1) begin
            k     <= '0;
            state <= S_W_GO;
          end else begin
            k     <= k + 1'b1;
            state <= S_SCAN;
          end
        end
        S_W_GO, S_W_WAIT: begin
          if (emit) begin
            result.camera_index <= 8'(pick[ki]);
            result.weight       <= (sum == '0) ? 17'd0 : div_q[16:0];
            result.last_out     <= (k == n - 1'b1);
            if (k == n - 1'b1) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_W_GO;
            end
          end else if (state == S_W_GO) begin
            state <= S_W_WAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_W_GO || state == S_W_WAIT))
    else $error("result strobe outside weight phase");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CAMERAS))
    else $error("camera count above store depth");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("not idle after reset");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_out |-> !busy && count == '0)
    else $error("last result did not end the query");

endmodule
